// ===== rtl/bhist_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bhist_pkg
// Shared types and constants for the byte value histogram.
// ----------------------------------------------------------------------------
package bhist_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int NUM_BINS       = 1 << BYTE_BITS;
    localparam int FIELD_BITS     = 32;
    localparam int CNT_BITS_DFLT  = 32;

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic                 opcode;
        logic [BYTE_BITS-1:0] byte_value;
    } t_hist_in;

    typedef struct packed {
        logic [FIELD_BITS-1:0] bin_count;
        logic [FIELD_BITS-1:0] total_count;
    } t_hist_out;

endpackage : bhist_pkg
`default_nettype wire

// ===== rtl/byte_histogram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_histogram
// 256-bin byte value histogram with a saturating running total.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_hist_in)
//   out     | output    | o_out_valid / i_out_stall| o_out_data (t_hist_out)
//
// Each transaction passes through the read stage and then the output
// register. One transaction per cycle is sustained while the output is not
// stalled; the bin memory's single read and single write port set that
// figure, with a write-to-read bypass covering back-to-back transactions
// that hit the same bin. Reset clears the 256 bin valid bits and the
// total; no clearing pass is needed, and a bin that was never written
// reads as zero. A stall on the output holds the read stage, which in
// turn stalls the input.
//
module byte_histogram
    import bhist_pkg::*;
#(
    parameter int COUNT_BITS = CNT_BITS_DFLT
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_hist_in  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_hist_out      o_out_data
);

    typedef logic [COUNT_BITS-1:0] t_cnt;

    // Saturating increment: hold at all ones.
    function automatic t_cnt sat_inc(input t_cnt v);
        sat_inc = (&v) ? v : t_cnt'(v + 1'b1);
    endfunction

    // Clamp a counter to the 32-bit result field.
    function automatic logic [FIELD_BITS-1:0] to_field(input t_cnt v);
        logic [63:0] w;
        w = 64'(v);
        to_field = (|w[63:FIELD_BITS]) ? '1 : w[FIELD_BITS-1:0];
    endfunction

    // Bin storage: one synchronous memory, valid bits in flops.
    t_cnt                  r_mem [NUM_BINS];
    logic [NUM_BINS-1:0]   r_bin_vld;

    // Read stage.
    logic                  r_s1_vld;
    t_hist_in              r_s1;
    t_cnt                  r_rd_data;
    logic                  r_rd_hit;

    // Running total and output register.
    t_cnt                  r_total;
    logic                  r_out_vld;
    t_hist_out             r_out;

    logic                  in_acc;
    logic                  s1_adv;
    logic                  wr_en;
    t_cnt                  old_bin;
    t_cnt                  n_bin;
    t_cnt                  n_total;
    logic                  fwd;

    // Advance the read stage when the output register is free or draining.
    assign s1_adv     = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Modify: a never-written bin reads as zero.
    assign old_bin = r_rd_hit ? r_rd_data : '0;
    assign n_bin   = (r_s1.opcode == OP_COUNT) ? sat_inc(old_bin) : old_bin;
    assign n_total = (r_s1.opcode == OP_COUNT) ? sat_inc(r_total) : r_total;
    assign wr_en   = s1_adv && (r_s1.opcode == OP_COUNT);

    // Bypass the write that lands on the same edge as a read of that bin.
    assign fwd = wr_en && (r_s1.byte_value == i_in_data.byte_value);

    // Memory read and write-back; hold the read data while stalled.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s1.byte_value] <= n_bin;
        end
        if (in_acc) begin
            r_s1 <= i_in_data;
            if (fwd) begin
                r_rd_data <= n_bin;
                r_rd_hit  <= 1'b1;
            end else begin
                r_rd_data <= r_mem[i_in_data.byte_value];
                r_rd_hit  <= r_bin_vld[i_in_data.byte_value];
            end
        end
        if (s1_adv) begin
            r_out.bin_count   <= to_field(n_bin);
            r_out.total_count <= to_field(n_total);
        end
    end

    // Control state: valid bits, stage flags, total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_vld <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_total   <= '0;
        end else begin
            if (wr_en) begin
                r_bin_vld[r_s1.byte_value] <= 1'b1;
                r_total                    <= n_total;
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // The total never goes backwards.
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_total >= $past(r_total)))
        else $error("total decreased");

    // Read data held while the read stage waits.
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |=> ($stable(r_rd_data) && $stable(r_rd_hit)))
        else $error("read data changed under stall");

    // A counted byte bumps an unsaturated total by exactly one.
    a_total_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && (r_s1.opcode == OP_COUNT) && !(&r_total))
        |=> (r_total == COUNT_BITS'($past(r_total) + 1'b1)))
        else $error("total did not advance");

    // A read transaction leaves the total alone.
    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && (r_s1.opcode == OP_READ)) |=> $stable(r_total))
        else $error("read changed total");
`endif

endmodule : byte_histogram
`default_nettype wire
